@@ src/tile_layer_pixel_fetch_defines.svh @@
// Assertion macros shared by the tile layer pixel fetch RTL.
// Depends on nothing; users must provide clk and rst_n in scope.
`ifndef TILE_LAYER_PIXEL_FETCH_DEFINES_SVH
`define TILE_LAYER_PIXEL_FETCH_DEFINES_SVH

// Checks a consequent in the same cycle as its antecedent.
`define TLPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks a consequent in the cycle after its antecedent.
`define TLPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/tlpf_pkg.sv @@
// Package for the tile layer pixel fetch: memory sizes, action codes,
// register offsets and the configuration struct. Depends on nothing.
package tlpf_pkg;

  localparam int VIDEO_WORDS = 262144;
  localparam int COLOR_WORDS = 2048;
  localparam int VRAM_AW     = $clog2(VIDEO_WORDS);
  localparam int VBYTE_AW    = VRAM_AW + 1;
  localparam int CRAM_AW     = $clog2(COLOR_WORDS);

  typedef logic [1:0] action_t;
  localparam action_t ACT_VIDEO_WR = 2'd0;
  localparam action_t ACT_COLOR_WR = 2'd1;
  localparam action_t ACT_RENDER   = 2'd2;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_LAYER_MODE   = 3'd0;
  localparam reg_idx_t REG_PALETTE_BANK = 3'd1;
  localparam reg_idx_t REG_PLANE_A      = 3'd2;
  localparam reg_idx_t REG_PLANE_B      = 3'd3;
  localparam reg_idx_t REG_PLANE_C      = 3'd4;
  localparam reg_idx_t REG_PLANE_D      = 3'd5;
  localparam reg_idx_t REG_SCROLL_X     = 3'd6;
  localparam reg_idx_t REG_SCROLL_Y     = 3'd7;

  typedef struct packed {
    logic [10:0]      layer_mode;
    logic [2:0]       palette_bank;
    logic [3:0][18:0] plane_start;
    logic [15:0]      scroll_x;
    logic [15:0]      scroll_y;
  } cfg_t;

endpackage

@@ src/tlpf_if.sv @@
// Channel interfaces for the tile layer pixel fetch: render/write items in,
// pixel results out. Depends on tlpf_pkg.
interface tlpf_in_if;
  logic              valid;
  logic              ready;
  tlpf_pkg::action_t action;
  logic [17:0]       address;
  logic [15:0]       data;
  logic [9:0]        pixel_x;
  logic [9:0]        pixel_y;
  modport source (output valid, action, address, data, pixel_x, pixel_y, input ready);
  modport sink   (input valid, action, address, data, pixel_x, pixel_y, output ready);
endinterface

interface tlpf_out_if;
  logic        valid;
  logic        ready;
  logic        opaque;
  logic [31:0] color;
  modport source (output valid, opaque, color, input ready);
  modport sink   (input valid, opaque, color, output ready);
endinterface

@@ src/tlpf_ram.sv @@
// Generic synchronous RAM with one write port and one or two registered
// read ports. Depends on nothing.
module tlpf_ram #(
  parameter int DEPTH     = 1024,
  parameter int WIDTH     = 16,
  parameter bit DUAL_READ = 1'b0,
  parameter int AW        = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr0,
  output logic [WIDTH-1:0] rdata0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
    end
  end

  if (DUAL_READ) begin : g_dual
    always_ff @(posedge clk) begin
      if (re) begin
        rdata1 <= mem[raddr1];
      end
    end
  end else begin : g_single
    assign rdata1 = (raddr1 == '0) ? '0 : '0;
  end

endmodule

@@ src/tlpf_cfg.sv @@
// APB-style register file for the tile layer pixel fetch configuration.
// Depends on tlpf_pkg.
module tlpf_cfg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output tlpf_pkg::cfg_t  cfg
);

  tlpf_pkg::cfg_t     cfg_r;
  tlpf_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr) begin
      case (idx)
        tlpf_pkg::REG_LAYER_MODE:   cfg_r.layer_mode     <= pwdata[10:0];
        tlpf_pkg::REG_PALETTE_BANK: cfg_r.palette_bank   <= pwdata[2:0];
        tlpf_pkg::REG_PLANE_A:      cfg_r.plane_start[0] <= pwdata[18:0];
        tlpf_pkg::REG_PLANE_B:      cfg_r.plane_start[1] <= pwdata[18:0];
        tlpf_pkg::REG_PLANE_C:      cfg_r.plane_start[2] <= pwdata[18:0];
        tlpf_pkg::REG_PLANE_D:      cfg_r.plane_start[3] <= pwdata[18:0];
        tlpf_pkg::REG_SCROLL_X:     cfg_r.scroll_x       <= pwdata[15:0];
        tlpf_pkg::REG_SCROLL_Y:     cfg_r.scroll_y       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tlpf_pkg::REG_LAYER_MODE:   prdata = {21'd0, cfg_r.layer_mode};
      tlpf_pkg::REG_PALETTE_BANK: prdata = {29'd0, cfg_r.palette_bank};
      tlpf_pkg::REG_PLANE_A:      prdata = {13'd0, cfg_r.plane_start[0]};
      tlpf_pkg::REG_PLANE_B:      prdata = {13'd0, cfg_r.plane_start[1]};
      tlpf_pkg::REG_PLANE_C:      prdata = {13'd0, cfg_r.plane_start[2]};
      tlpf_pkg::REG_PLANE_D:      prdata = {13'd0, cfg_r.plane_start[3]};
      tlpf_pkg::REG_SCROLL_X:     prdata = {16'd0, cfg_r.scroll_x};
      tlpf_pkg::REG_SCROLL_Y:     prdata = {16'd0, cfg_r.scroll_y};
      default:                    prdata = '0;
    endcase
  end

endmodule

@@ src/tlpf_pipe.sv @@
// Five-stage pixel pipeline of the tile layer: map address, name fetch,
// dot fetch, color fetch, output register. Depends on tlpf_pkg, tlpf_if,
// tlpf_ram and tile_layer_pixel_fetch_defines.svh.
`include "tile_layer_pixel_fetch_defines.svh"
module tlpf_pipe (
  input  logic            clk,
  input  logic            rst_n,
  input  tlpf_pkg::cfg_t  cfg,
  tlpf_in_if.sink         in_chan,
  tlpf_out_if.source      out_chan
);

  localparam int AW  = tlpf_pkg::VRAM_AW;
  localparam int BW  = tlpf_pkg::VBYTE_AW;
  localparam int CAW = tlpf_pkg::CRAM_AW;

  logic adv;
  logic out_valid_r, out_opaque_r;
  logic [31:0] out_color_r;

  assign adv            = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = adv;
  assign out_chan.valid = out_valid_r;
  assign out_chan.opaque = out_opaque_r;
  assign out_chan.color = out_color_r;

  logic big, deep, one_word, num_mode, wide, high;
  logic [4:0] supp;
  assign big      = cfg.layer_mode[0];
  assign deep     = cfg.layer_mode[1];
  assign one_word = cfg.layer_mode[2];
  assign num_mode = cfg.layer_mode[3];
  assign wide     = cfg.layer_mode[4];
  assign high     = cfg.layer_mode[5];
  assign supp     = cfg.layer_mode[10:6];

  // Stage A: scrolled coordinate.
  logic              a_v_r;
  tlpf_pkg::action_t a_act_r;
  logic [17:0]       a_addr_r;
  logic [15:0]       a_data_r;
  logic [16:0]       a_sx_r, a_sy_r;
  logic [16:0]       sx_nxt, sy_nxt;

  assign sx_nxt = {7'd0, in_chan.pixel_x} + {cfg.scroll_x[15], cfg.scroll_x};
  assign sy_nxt = {7'd0, in_chan.pixel_y} + {cfg.scroll_y[15], cfg.scroll_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_act_r  <= in_chan.action;
      a_addr_r <= in_chan.address;
      a_data_r <= in_chan.data;
      a_sx_r   <= sx_nxt;
      a_sy_r   <= sy_nxt;
    end
  end

  logic [15:0] ax, ay;
  logic        plane_x, plane_y, page_c, page_r, a_neg;
  logic [1:0]  page_no, a_cell;
  logic [13:0] name_idx;
  logic [15:0] name_off;
  logic [19:0] name_sum;
  logic [BW-1:0] name_byte;
  logic [AW-1:0] name_w1, name_w2;

  assign ax       = a_sx_r[15:0];
  assign ay       = a_sy_r[15:0];
  assign a_neg    = a_sx_r[16] || a_sy_r[16];
  assign plane_x  = wide ? ax[10] : ax[9];
  assign plane_y  = high ? ay[10] : ay[9];
  assign page_c   = wide && ax[9];
  assign page_r   = high && ay[9];
  assign page_no  = wide ? {page_r, page_c} : {1'b0, page_r};
  assign name_idx = big ? {2'd0, page_no, ay[8:4], ax[8:4]} : {page_no, ay[8:3], ax[8:3]};
  assign name_off = one_word ? {1'b0, name_idx, 1'b0} : {name_idx, 2'b00};
  assign name_sum = {1'b0, cfg.plane_start[{plane_y, plane_x}]} + {4'd0, name_off};
  assign name_byte = name_sum[BW-1:0];
  assign name_w1  = name_byte[BW-1:1];
  assign name_w2  = name_w1 + AW'(1);
  assign a_cell   = big ? {ay[3], ax[3]} : 2'b00;

  logic [15:0] nw1, nw2;

  tlpf_ram #(.DEPTH(tlpf_pkg::VIDEO_WORDS), .WIDTH(16), .DUAL_READ(1'b1)) u_name_ram (
    .clk    (clk),
    .we     (adv && a_v_r && a_act_r == tlpf_pkg::ACT_VIDEO_WR),
    .waddr  (a_addr_r[AW-1:0]),
    .wdata  (a_data_r),
    .re     (adv),
    .raddr0 (name_w1),
    .rdata0 (nw1),
    .raddr1 (name_w2),
    .rdata1 (nw2)
  );

  // Stage B: pattern name decode and dot address.
  logic              b_v_r, b_neg_r;
  tlpf_pkg::action_t b_act_r;
  logic [17:0]       b_addr_r;
  logic [15:0]       b_data_r;
  logic [1:0]        b_cell_r;
  logic [2:0]        b_dx_r, b_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_act_r  <= a_act_r;
      b_addr_r <= a_addr_r;
      b_data_r <= a_data_r;
      b_neg_r  <= a_neg;
      b_cell_r <= a_cell;
      b_dx_r   <= ax[2:0];
      b_dy_r   <= ay[2:0];
    end
  end

  logic [14:0] char_no;
  logic [6:0]  pal_no;
  logic [19:0] dot_sum;
  logic [BW-1:0] dot_byte;

  always_comb begin
    if (one_word) begin
      pal_no = {3'd0, nw1[15:12]};
      case ({num_mode, big})
        2'b00:   char_no = {supp, nw1[9:0]};
        2'b01:   char_no = {supp[4:2], nw1[9:0], supp[1:0]};
        2'b10:   char_no = {supp[4:2], nw1[11:0]};
        default: char_no = {supp[4], nw1[11:0], supp[1:0]};
      endcase
    end else begin
      pal_no  = nw1[6:0];
      char_no = nw2[14:0];
    end
  end

  assign dot_sum = {char_no, 5'd0}
                 + (deep ? {12'd0, b_cell_r, 6'd0} : {13'd0, b_cell_r, 5'd0})
                 + (deep ? {14'd0, b_dy_r, b_dx_r} : {15'd0, b_dy_r, b_dx_r[2:1]});
  assign dot_byte = dot_sum[BW-1:0];

  logic [15:0] dot_word;

  tlpf_ram #(.DEPTH(tlpf_pkg::VIDEO_WORDS), .WIDTH(16), .DUAL_READ(1'b0)) u_dot_ram (
    .clk    (clk),
    .we     (adv && b_v_r && b_act_r == tlpf_pkg::ACT_VIDEO_WR),
    .waddr  (b_addr_r[AW-1:0]),
    .wdata  (b_data_r),
    .re     (adv),
    .raddr0 (dot_byte[BW-1:1]),
    .rdata0 (dot_word),
    .raddr1 ('0),
    .rdata1 ()
  );

  // Stage C: dot extract and color index.
  logic              c_v_r, c_neg_r, c_lsb_r, c_dx0_r;
  tlpf_pkg::action_t c_act_r;
  logic [17:0]       c_addr_r;
  logic [15:0]       c_data_r;
  logic [6:0]        c_pal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_act_r  <= b_act_r;
      c_addr_r <= b_addr_r;
      c_data_r <= b_data_r;
      c_neg_r  <= b_neg_r;
      c_pal_r  <= pal_no;
      c_lsb_r  <= dot_byte[0];
      c_dx0_r  <= b_dx_r[0];
    end
  end

  logic [7:0]  dot_b, dot;
  logic [11:0] cidx;
  logic        c_opq;

  assign dot_b = c_lsb_r ? dot_word[7:0] : dot_word[15:8];
  assign dot   = deep ? dot_b : {4'd0, (c_dx0_r ? dot_b[3:0] : dot_b[7:4])};
  assign cidx  = {1'b0, c_pal_r, 4'd0} + {4'd0, dot} + {1'b0, cfg.palette_bank, 8'd0};
  assign c_opq = (dot != 8'd0) && !c_neg_r;

  logic [15:0] cword;

  tlpf_ram #(.DEPTH(tlpf_pkg::COLOR_WORDS), .WIDTH(16), .DUAL_READ(1'b0)) u_color_ram (
    .clk    (clk),
    .we     (adv && c_v_r && c_act_r == tlpf_pkg::ACT_COLOR_WR),
    .waddr  (c_addr_r[CAW-1:0]),
    .wdata  (c_data_r),
    .re     (adv),
    .raddr0 (cidx[CAW-1:0]),
    .rdata0 (cword),
    .raddr1 ('0),
    .rdata1 ()
  );

  // Stage D: colour conversion into the output register.
  logic              d_v_r, d_opq_r;
  tlpf_pkg::action_t d_act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      d_v_r       <= c_v_r;
      out_valid_r <= d_v_r && d_act_r == tlpf_pkg::ACT_RENDER;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_act_r      <= c_act_r;
      d_opq_r      <= c_opq;
      out_opaque_r <= d_opq_r;
      out_color_r  <= d_opq_r ? {8'hFF, cword[14:10], 3'd0, cword[9:5], 3'd0,
                                 cword[4:0], 3'd0} : 32'd0;
    end
  end

  `TLPF_ASSERT_NEXT(a_stall_holds, !adv, $stable({a_v_r, b_v_r, c_v_r, d_v_r}), "stage moved while stalled")
  `TLPF_ASSERT_NEXT(a_write_silent, adv && d_v_r && d_act_r != tlpf_pkg::ACT_RENDER, !out_valid_r, "write item produced a result")
  `TLPF_ASSERT_NEXT(a_render_emits, adv && d_v_r && d_act_r == tlpf_pkg::ACT_RENDER, out_valid_r, "render item lost")
  `TLPF_ASSERT_NOW(a_clear_black, out_valid_r && !out_opaque_r, out_color_r == 32'd0, "transparent pixel has colour")

endmodule

@@ src/tile_layer_pixel_fetch.sv @@
// Top level of the tile layer pixel fetch: register file and pixel pipeline.
// Depends on tlpf_pkg, tlpf_if, tlpf_cfg and tlpf_pipe.
//
// Usage: items arrive on in_chan (valid/ready). Action 0 writes a video
// memory word, action 1 writes a colour memory word, action 2 renders the
// pixel at (pixel_x, pixel_y); action 3 is dropped. Each render item gives
// exactly one transfer on out_chan with opaque and a 32-bit colour; writes
// give none. Registers are to be written through the APB-style port (psel,
// penable, pwrite, paddr, pwdata) only while no item is in flight; the block
// itself does not enforce this. Throughput is one item per cycle while
// out_chan does not stall: the pipeline has four stages plus an output
// register, and each memory is read once per item at its own stage. A render
// result passes through stages A, B, C and D and the output register before
// it is valid on out_chan. A write reaches each memory copy at the stage
// where that memory is read, so later renders always see it. Reset (rst_n
// low, synchronous) clears the registers and all valid bits; memory contents
// are undefined until written. When out_chan stalls, the whole pipeline
// holds and in_chan.ready falls; nothing is lost or repeated.
module tile_layer_pixel_fetch (
  input  logic        clk,
  input  logic        rst_n,
  tlpf_in_if.sink     in_chan,
  tlpf_out_if.source  out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tlpf_pkg::cfg_t cfg;

  tlpf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tlpf_pipe u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule

@@ dv/tlpf_scoreboard.sv @@
// Scoreboard for the tile layer pixel fetch: a predictor with its own copy of both memories
// and the registers, and the queue of expected pixels. Depends on tlpf_pkg.
class tlpf_scoreboard;
  typedef struct {
    bit          opaque;
    logic [31:0] color;
  } pixel_t;

  logic [15:0] vmem [tlpf_pkg::VIDEO_WORDS];
  bit          vwritten [tlpf_pkg::VIDEO_WORDS];
  logic [15:0] cmem [tlpf_pkg::COLOR_WORDS];
  bit          cwritten [tlpf_pkg::COLOR_WORDS];

  logic [10:0] layer_mode;
  logic [2:0]  palette_bank;
  logic [18:0] plane_start [4];
  logic [15:0] scroll_x;
  logic [15:0] scroll_y;

  pixel_t pixels_due [$];
  int     errors;

  // First unwritten entry touched by the latest prediction: 0 none, 1 video, 2 colour.
  int          miss_kind;
  logic [17:0] miss_idx;

  function new();
    layer_mode = 0;
    palette_bank = 0;
    foreach (plane_start[i]) plane_start[i] = 0;
    scroll_x = 0;
    scroll_y = 0;
    errors = 0;
  endfunction

  function void set_reg(tlpf_pkg::reg_idx_t idx, logic [31:0] value);
    case (idx)
      tlpf_pkg::REG_LAYER_MODE: begin
        layer_mode = value[10:0];
      end
      tlpf_pkg::REG_PALETTE_BANK: begin
        palette_bank = value[2:0];
      end
      tlpf_pkg::REG_SCROLL_X: begin
        scroll_x = value[15:0];
      end
      tlpf_pkg::REG_SCROLL_Y: begin
        scroll_y = value[15:0];
      end
      default: begin
        plane_start[idx - tlpf_pkg::REG_PLANE_A] = value[18:0];
      end
    endcase
  endfunction

  function logic [15:0] vword(logic [31:0] ba);
    logic [17:0] idx;
    idx = ba[18:1];
    if (!vwritten[idx] && miss_kind == 0) begin
      miss_kind = 1;
      miss_idx = idx;
    end
    return vmem[idx];
  endfunction

  function logic [7:0] vbyte(logic [31:0] ba);
    logic [15:0] w;
    w = vword(ba);
    return ba[0] ? w[7:0] : w[15:8];
  endfunction

  function pixel_t shade(logic [9:0] px, logic [9:0] py);
    pixel_t r;
    int sx, sy;
    int unsigned x, y, wide, high, plane_w, plane_h, plane_x, plane_y, ipx, ipy, page_no;
    int unsigned pgx, pgy, pat_dots, page_dim, name_bytes, page_bytes, pat_no;
    int unsigned ptx, pty, cell_idx, dx, dy, supp, pal_no, dot;
    logic [31:0] name_addr, char_no, cell_addr, pn, cofs, c;
    logic [7:0] b;
    miss_kind = 0;
    r.opaque = 0;
    r.color = 0;
    sx = int'(px) + int'($signed(scroll_x));
    sy = int'(py) + int'($signed(scroll_y));
    if (sx < 0 || sy < 0) return r;
    x = sx;
    y = sy;
    wide = layer_mode[4] ? 2 : 1;
    high = layer_mode[5] ? 2 : 1;
    supp = layer_mode[10:6];
    plane_w = 512 * wide;
    plane_h = 512 * high;
    plane_x = (x / plane_w) & 1;
    plane_y = (y / plane_h) & 1;
    ipx = x % plane_w;
    ipy = y % plane_h;
    page_no = (ipy / 512) * wide + ipx / 512;
    pgx = ipx & 511;
    pgy = ipy & 511;
    pat_dots = layer_mode[0] ? 16 : 8;
    page_dim = layer_mode[0] ? 32 : 64;
    name_bytes = layer_mode[2] ? 2 : 4;
    page_bytes = page_dim * page_dim * name_bytes;
    pat_no = (pgy / pat_dots) * page_dim + pgx / pat_dots;
    ptx = pgx % pat_dots;
    pty = pgy % pat_dots;
    cell_idx = (ptx >> 3) + (pty >> 3) * 2;
    dx = ptx & 7;
    dy = pty & 7;
    name_addr = plane_start[plane_y * 2 + plane_x] + page_no * page_bytes + pat_no * name_bytes;
    if (layer_mode[2]) begin
      pn = vword(name_addr);
      pal_no = pn[15:12];
      if (!layer_mode[3]) begin
        if (!layer_mode[0]) char_no = (pn & 32'h3FF) | ((supp & 32'h1F) << 10);
        else char_no = ((pn & 32'h3FF) << 2) | (supp & 3) | ((supp & 32'h1C) << 10);
      end else begin
        if (!layer_mode[0]) char_no = (pn & 32'hFFF) | ((supp & 32'h1C) << 10);
        else char_no = ((pn & 32'hFFF) << 2) | (supp & 3) | ((supp & 32'h10) << 10);
      end
    end else begin
      pal_no = vword(name_addr) & 32'h7F;
      char_no = vword(name_addr + 2) & 32'h7FFF;
    end
    cell_addr = char_no * 32'h20 + cell_idx * (layer_mode[1] ? 64 : 32);
    if (layer_mode[1]) begin
      dot = vbyte(cell_addr + dy * 8 + dx);
    end else begin
      b = vbyte(cell_addr + dy * 4 + (dx >> 1));
      dot = dx[0] ? b[3:0] : b[7:4];
    end
    if (dot == 0) return r;
    cofs = ((pal_no << 4) + dot) * 2 + palette_bank * 32'h200;
    if (!cwritten[cofs[11:1]] && miss_kind == 0) begin
      miss_kind = 2;
      miss_idx = cofs[11:1];
    end
    c = cmem[cofs[11:1]];
    r.opaque = 1;
    r.color = 32'hFF000000 | ((c & 32'h1F) << 3) | ((c & 32'h03E0) << 6)
            | ((c & 32'h7C00) << 9);
    return r;
  endfunction

  function void note_input(tlpf_pkg::action_t action, logic [17:0] address,
                           logic [15:0] data, logic [9:0] px, logic [9:0] py);
    case (action)
      tlpf_pkg::ACT_VIDEO_WR: begin
        vmem[address] = data;
        vwritten[address] = 1;
      end
      tlpf_pkg::ACT_COLOR_WR: begin
        cmem[address[10:0]] = data;
        cwritten[address[10:0]] = 1;
      end
      tlpf_pkg::ACT_RENDER: begin
        pixels_due.push_back(shade(px, py));
      end
      default: begin
      end
    endcase
  endfunction

  function void check_result(bit opaque, logic [31:0] color);
    pixel_t e;
    if (pixels_due.size() == 0) begin
      $error("pixel transfer with nothing expected");
      errors++;
      return;
    end
    e = pixels_due.pop_front();
    if (opaque !== e.opaque) begin
      $error("opaque: expected %0d, actual %0d", e.opaque, opaque);
      errors++;
    end
    if (color !== e.color) begin
      $error("color: expected %h, actual %h", e.color, color);
      errors++;
    end
  endfunction
endclass

@@ dv/tb_tile_layer_pixel_fetch.sv @@
// Top of the tile layer pixel fetch testbench: drives items, registers and output stalls.
// Depends on tlpf_pkg, tlpf_if, the scoreboard class and the block itself.
module tb_tile_layer_pixel_fetch;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  bit          no_idle;

  tlpf_in_if  in_if();
  tlpf_out_if out_if();
  tlpf_scoreboard sb;

  tile_layer_pixel_fetch dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if), .out_chan(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.opaque, out_if.color);
  end

  int stall_left;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready = 0;
    end else begin
      out_if.ready = 1;
      if (!no_idle && $urandom_range(0, 5) == 0)
        stall_left = int'(($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3));
    end
  end

  task automatic send(tlpf_pkg::action_t action, logic [17:0] address, logic [15:0] data,
                      logic [9:0] px, logic [9:0] py);
    @(negedge clk);
    in_if.valid = 1;
    in_if.action = action;
    in_if.address = address;
    in_if.data = data;
    in_if.pixel_x = px;
    in_if.pixel_y = py;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(action, address, data, px, py);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_if.valid = 0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2))
        @(negedge clk);
    end
  endtask

  // Fills every entry that the pixel would read and that was never written, then renders it.
  task automatic render(logic [9:0] px, logic [9:0] py);
    forever begin
      void'(sb.shade(px, py));
      if (sb.miss_kind == 0) break;
      if (sb.miss_kind == 1)
        send(tlpf_pkg::ACT_VIDEO_WR, sb.miss_idx, 16'($urandom), 10'($urandom), 10'($urandom));
      else
        send(tlpf_pkg::ACT_COLOR_WR, {7'($urandom), sb.miss_idx[10:0]}, 16'($urandom),
             10'($urandom), 10'($urandom));
    end
    send(tlpf_pkg::ACT_RENDER, 18'($urandom), 16'($urandom), px, py);
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid = 0;
    while (sb.pixels_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic reg_write(tlpf_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel = 1;
    penable = 0;
    pwrite = 1;
    paddr = 5'(idx) << 2;
    pwdata = value;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel = 0;
    penable = 0;
  endtask

  task automatic set_all(logic [10:0] mode, logic [2:0] bank, logic [18:0] pa, logic [18:0] pb,
                         logic [18:0] pc, logic [18:0] pd, logic [15:0] sx, logic [15:0] sy);
    reg_write(tlpf_pkg::REG_LAYER_MODE, {21'd0, mode});
    reg_write(tlpf_pkg::REG_PALETTE_BANK, {29'd0, bank});
    reg_write(tlpf_pkg::REG_PLANE_A, {13'd0, pa});
    reg_write(tlpf_pkg::REG_PLANE_B, {13'd0, pb});
    reg_write(tlpf_pkg::REG_PLANE_C, {13'd0, pc});
    reg_write(tlpf_pkg::REG_PLANE_D, {13'd0, pd});
    reg_write(tlpf_pkg::REG_SCROLL_X, {16'd0, sx});
    reg_write(tlpf_pkg::REG_SCROLL_Y, {16'd0, sy});
  endtask

  task automatic random_phase(int n);
    int k, r;
    k = 0;
    while (k < n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        render(10'($urandom), 10'($urandom));
        k++;
      end else if (r < 85) begin
        send(tlpf_pkg::ACT_VIDEO_WR, 18'($urandom), 16'($urandom), 10'($urandom),
             10'($urandom));
        k++;
      end else if (r < 93) begin
        send(tlpf_pkg::ACT_COLOR_WR, 18'($urandom), 16'($urandom), 10'($urandom),
             10'($urandom));
        k++;
      end else begin
        send(tlpf_pkg::action_t'(3), 18'($urandom), 16'($urandom), 10'($urandom),
             10'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    no_idle = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    in_if.valid = 0;
    in_if.action = tlpf_pkg::ACT_VIDEO_WR;
    in_if.address = 0;
    in_if.data = 0;
    in_if.pixel_x = 0;
    in_if.pixel_y = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: corner pixels, extreme write fields, the unused action and negative coordinates.
    send(tlpf_pkg::ACT_VIDEO_WR, 18'h3FFFF, 16'hFFFF, 10'd0, 10'd0);
    send(tlpf_pkg::ACT_COLOR_WR, 18'h3FFFF, 16'hFFFF, 10'd0, 10'd0);
    send(tlpf_pkg::ACT_VIDEO_WR, 18'h0, 16'h0, 10'h3FF, 10'h3FF);
    send(tlpf_pkg::action_t'(3), 18'h3FFFF, 16'hFFFF, 10'h3FF, 10'h3FF);
    render(10'd0, 10'd0);
    render(10'h3FF, 10'h3FF);
    render(10'h3FF, 10'd0);
    drain();
    set_all(11'h7FF, 3'h7, 19'h7FFFF, 19'h7FFFF, 19'h7FFFF, 19'h7FFFF, 16'h7FFF, 16'h7FFF);
    render(10'd0, 10'd0);
    render(10'h3FF, 10'h3FF);
    render(10'h155, 10'h2AA);
    drain();
    set_all(11'h004, 3'h0, 19'h0, 19'h1000, 19'h2000, 19'h3000, 16'h8000, 16'h0);
    render(10'h3FF, 10'h3FF);
    render(10'd0, 10'd0);
    drain();
    reg_write(tlpf_pkg::REG_SCROLL_X, 32'h0000FFFF);
    reg_write(tlpf_pkg::REG_SCROLL_Y, 32'h00008000);
    render(10'd0, 10'h3FF);
    render(10'd1, 10'd1);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 0) begin
        set_all(11'd0, 3'd0, 19'd0, 19'd0, 19'd0, 19'd0, 16'd0, 16'd0);
      end else if (ph == 1) begin
        set_all(11'h7FF, 3'd7, 19'h7FFFF, 19'd0, 19'h7FFFF, 19'd0, 16'h7FFF, 16'h8000);
      end else begin
        set_all(11'($urandom), 3'($urandom), 19'($urandom), 19'($urandom), 19'($urandom),
                19'($urandom),
                16'($signed($urandom_range(0, 2400)) - 400),
                16'($signed($urandom_range(0, 2400)) - 400));
      end
      no_idle = (ph == 4);
      random_phase(80);
      drain();
    end

    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

@@ tile_layer_pixel_fetch.f @@
+incdir+src
src/tlpf_pkg.sv
src/tlpf_if.sv
src/tlpf_ram.sv
src/tlpf_cfg.sv
src/tlpf_pipe.sv
src/tile_layer_pixel_fetch.sv
dv/tlpf_scoreboard.sv
dv/tb_tile_layer_pixel_fetch.sv
